/* sv/assert_macros.svh */
// Assertion macros used by the checker of the trigger qualifier table.
// Depends on nothing; each macro wraps one clocked concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property with an overlapping implication or a plain expression.
`define ETQ_ASSERT_IMPL(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define ETQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/etq_pkg.sv */
// Package of the trigger qualifier table: sizes, command, phase and state codes,
// transfer structs and the layout of one slot entry. Depends on nothing.
`default_nettype none

package etq_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int TIME_BITS   = 16;
  localparam int EP_BITS     = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int CHG_W       = 4;
  localparam int IDX_W       = 4;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_RESET    = 2'd0,
    PH_PRESET   = 2'd1,
    PH_SET      = 2'd2,
    PH_PRERESET = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    cmd_t                 command;
    logic [EP_BITS-1:0]   endpoint_id;
    logic                 condition_met;
    logic [IDX_W-1:0]     slot_index;
    logic [TIME_BITS-1:0] detect_ticks;
    logic [TIME_BITS-1:0] hold_ticks;
  } in_t;

  typedef struct packed {
    logic [CHG_W-1:0] changed_slot;
    logic             now_set;
    logic             last_result;
  } out_t;

  typedef struct packed {
    logic [EP_BITS-1:0]   endpoint;
    logic [TIME_BITS-1:0] detect_time;
    logic [TIME_BITS-1:0] hold_time;
    phase_t               phase;
    logic [TIME_BITS-1:0] detect_rem;
    logic [TIME_BITS-1:0] hold_rem;
  } entry_t;

endpackage

`default_nettype wire

/* sv/etq_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; width and depth come from its parameters.
`default_nettype none

module etq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/event_trigger_qualifier_table.sv */
// Trigger qualifier table. A tick or an update transfer holds busy high
// through the sweep and the flush, and no transfer is taken while busy is high:
// the sweep reads one slot entry per cycle from the slot memory and writes it
// back in the next cycle, then the flush state drains the last notification.
// Load and delete never raise busy. A tick delivers its notifications in
// ascending slot order, one per cycle at most, each held on result for exactly
// one cycle with strobe high; the receiver cannot stall and must take them as
// they come. Depends on etq_pkg and etq_ram.
`default_nettype none

module event_trigger_qualifier_table (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire etq_pkg::in_t item,
  output logic              strobe,
  output etq_pkg::out_t     result
);

  localparam int SW = etq_pkg::SLOT_W;
  localparam int EW = $bits(etq_pkg::entry_t);

  etq_pkg::state_t state, state_next;
  etq_pkg::cmd_t   op;
  logic [etq_pkg::EP_BITS-1:0] op_ep;
  logic                        op_cond;
  logic [SW:0]                 rd_cnt;
  logic                        proc_vld;
  logic [SW-1:0]               proc_idx;
  logic [etq_pkg::CNT_W-1:0]   fire_cnt;
  logic                        pend_vld;
  logic [etq_pkg::CHG_W-1:0]   pend_slot;
  logic                        pend_set;
  logic [etq_pkg::NUM_SLOTS-1:0] slot_valid;

  logic             accept, idx_ok, issue, last_proc, proc_live;
  logic             fire, fire_set;
  logic             we;
  logic [SW-1:0]    waddr;
  logic [EW-1:0]    wdata, rdata;
  etq_pkg::entry_t  ent, upd, load_ent;

  assign busy      = (state != etq_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign idx_ok    = (32'(item.slot_index) < etq_pkg::NUM_SLOTS);
  assign issue     = (state == etq_pkg::ST_SWEEP) && (32'(rd_cnt) < etq_pkg::NUM_SLOTS);
  assign last_proc = proc_vld && (proc_idx == SW'(etq_pkg::NUM_SLOTS - 1));
  assign proc_live = proc_vld && slot_valid[proc_idx];
  assign ent       = etq_pkg::entry_t'(rdata);

  always_comb begin
    upd      = ent;
    fire     = 1'b0;
    fire_set = 1'b0;
    if (op == etq_pkg::CMD_TICK) begin
      if (ent.detect_rem != '0) begin
        upd.detect_rem = ent.detect_rem - 1'b1;
      end
      if (ent.hold_rem != '0) begin
        upd.hold_rem = ent.hold_rem - 1'b1;
      end
      if (32'(fire_cnt) < etq_pkg::MAX_RESULTS) begin
        if (ent.phase == etq_pkg::PH_PRESET && upd.detect_rem == '0) begin
          upd.phase    = etq_pkg::PH_SET;
          upd.hold_rem = ent.hold_time;
          fire         = 1'b1;
          fire_set     = 1'b1;
        end else if (ent.phase == etq_pkg::PH_PRERESET && upd.hold_rem == '0) begin
          upd.phase = etq_pkg::PH_RESET;
          fire      = 1'b1;
        end
      end
    end else if (ent.endpoint == op_ep) begin
      case (ent.phase)
        etq_pkg::PH_RESET: begin
          if (op_cond) begin
            upd.detect_rem = ent.detect_time;
            upd.phase      = etq_pkg::PH_PRESET;
          end
        end
        etq_pkg::PH_PRESET: begin
          if (!op_cond) begin
            upd.detect_rem = '0;
            upd.phase      = etq_pkg::PH_RESET;
          end
        end
        etq_pkg::PH_SET: begin
          if (!op_cond) begin
            upd.phase = etq_pkg::PH_PRERESET;
          end
        end
        default: begin
          if (op_cond) begin
            upd.phase = etq_pkg::PH_SET;
          end
        end
      endcase
    end
  end

  always_comb begin
    load_ent.endpoint    = item.endpoint_id;
    load_ent.detect_time = item.detect_ticks;
    load_ent.hold_time   = item.hold_ticks;
    load_ent.phase       = etq_pkg::PH_RESET;
    load_ent.detect_rem  = '0;
    load_ent.hold_rem    = '0;
    if (accept && item.command == etq_pkg::CMD_LOAD) begin
      we    = idx_ok;
      waddr = SW'(item.slot_index);
      wdata = load_ent;
    end else begin
      we    = proc_live;
      waddr = proc_idx;
      wdata = upd;
    end
  end

  etq_ram #(
    .WIDTH (EW),
    .DEPTH (etq_pkg::NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (rd_cnt[SW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      etq_pkg::ST_IDLE: begin
        if (accept && (item.command == etq_pkg::CMD_TICK ||
                       item.command == etq_pkg::CMD_UPDATE)) begin
          state_next = etq_pkg::ST_SWEEP;
        end
      end
      etq_pkg::ST_SWEEP: begin
        if (last_proc) begin
          state_next = etq_pkg::ST_FLUSH;
        end
      end
      etq_pkg::ST_FLUSH: begin
        state_next = etq_pkg::ST_IDLE;
      end
      default: begin
        state_next = etq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= etq_pkg::ST_IDLE;
      rd_cnt     <= '0;
      proc_vld   <= 1'b0;
      fire_cnt   <= '0;
      pend_vld   <= 1'b0;
      strobe     <= 1'b0;
      slot_valid <= '0;
    end else begin
      state    <= state_next;
      proc_vld <= issue;
      strobe   <= pend_vld && ((proc_live && fire) ||
                               (state == etq_pkg::ST_FLUSH));
      if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (accept) begin
        rd_cnt   <= '0;
        fire_cnt <= '0;
        pend_vld <= 1'b0;
        if (idx_ok && item.command == etq_pkg::CMD_LOAD) begin
          slot_valid[SW'(item.slot_index)] <= 1'b1;
        end
        if (idx_ok && item.command == etq_pkg::CMD_DELETE) begin
          slot_valid[SW'(item.slot_index)] <= 1'b0;
        end
      end
      if (proc_live && fire) begin
        fire_cnt <= fire_cnt + 1'b1;
        pend_vld <= 1'b1;
      end
      if (state == etq_pkg::ST_FLUSH && pend_vld) begin
        pend_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= item.command;
      op_ep   <= item.endpoint_id;
      op_cond <= item.condition_met;
    end
    if (issue) begin
      proc_idx <= rd_cnt[SW-1:0];
    end
    if (proc_live && fire) begin
      pend_slot <= etq_pkg::CHG_W'(proc_idx);
      pend_set  <= fire_set;
      result.changed_slot <= pend_slot;
      result.now_set      <= pend_set;
      result.last_result  <= 1'b0;
    end
    if (state == etq_pkg::ST_FLUSH) begin
      result.changed_slot <= pend_slot;
      result.now_set      <= pend_set;
      result.last_result  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* sv/etq_checker.sv */
// Port-level checker for the trigger qualifier table and its bind statement.
// Depends on etq_pkg, assert_macros.svh and the top level event_trigger_qualifier_table.
`default_nettype none
`include "assert_macros.svh"

module etq_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         start,
  input wire logic         busy,
  input wire etq_pkg::in_t item,
  input wire logic         strobe,
  input wire etq_pkg::out_t result
);

  // A notification that is not the last of its tick leaves more work in flight.
  `ETQ_ASSERT_IMPL(a_more_while_busy, clk, rst, (strobe && !result.last_result) |-> busy, "non-final notification while idle")
  // No notification follows directly on an accepted transfer.
  `ETQ_ASSERT_NEXT(a_no_early_result, clk, rst, start && !busy, !strobe, "notification right after a transfer")
  // The last notification of a tick is followed by a quiet cycle.
  `ETQ_ASSERT_NEXT(a_last_is_last, clk, rst, strobe && result.last_result, !strobe, "notification after the final one")
  // Ticks and updates start a sweep of the table.
  `ETQ_ASSERT_NEXT(a_sweep_starts, clk, rst, start && !busy && (item.command == etq_pkg::CMD_TICK || item.command == etq_pkg::CMD_UPDATE), busy, "sweep did not start")
  // Loads and deletes complete in the cycle they are taken.
  `ETQ_ASSERT_NEXT(a_table_write_quick, clk, rst, start && !busy && (item.command == etq_pkg::CMD_LOAD || item.command == etq_pkg::CMD_DELETE), !busy, "slot write left the block busy")

endmodule

bind event_trigger_qualifier_table etq_checker u_etq_checker (.*);

`default_nettype wire
